FILE: hdl/glb_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// glb_pkg: shared types and constants for the greedy line breaker
// Width of the 1/64 px width and advance fields, the Q4.12 rounding constants,
// the code points that the breaker treats as special, and the config register
// indexes.
// ----------------------------------------------------------------------------
package glb_pkg;

  localparam int unsigned WID_W   = 24;  // line width, 1/64 px
  localparam int unsigned GADV_W  = 16;  // unscaled glyph advance
  localparam int unsigned SCALE_W = 16;  // Q4.12 advance scale
  localparam int unsigned FRAC_W  = 12;  // fraction bits of the scale
  localparam int unsigned CP_W    = 21;  // code point
  localparam int unsigned LEN_W   = 3;   // UTF-8 byte count
  localparam int unsigned MODE_W  = 2;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DAT_W = 24;

  localparam logic [WID_W-1:0]   WID_MAX     = {WID_W{1'b1}};
  localparam logic [SCALE_W-1:0] SCALE_RESET = 16'd4096;

  localparam logic [CP_W-1:0] CP_NEWLINE = 21'd10;
  localparam logic [CP_W-1:0] CP_SPACE   = 21'd32;
  localparam logic [CP_W-1:0] CP_TAB     = 21'd9;

  localparam logic CMD_CHAR = 1'b0;
  localparam logic CMD_EOT  = 1'b1;

  typedef enum logic [MODE_W-1:0] {
    MODE_NONE  = 2'd0,
    MODE_CHAR  = 2'd1,
    MODE_SPACE = 2'd2,
    MODE_ALT   = 2'd3   // unused code, acts as MODE_CHAR
  } glb_mode_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_WRAP_MODE  = 2'd0,
    CFG_WRAP_WIDTH = 2'd1,
    CFG_ADV_SCALE  = 2'd2,
    CFG_UNUSED     = 2'd3
  } glb_cfg_idx_t;

  // One input beat after decode, held in the input register.
  typedef struct packed {
    logic             eot;       // end of text
    logic             newline;
    logic             brk_char;  // space or tab
    logic [LEN_W-1:0] len;
    logic [WID_W-1:0] adv;       // scaled advance
  } glb_item_t;

endpackage

FILE: hdl/glb_advance.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// glb_advance: glyph advance scaling
// Scales the raw advance by the Q4.12 factor with round half up; a missing
// glyph gives zero.
// ----------------------------------------------------------------------------
module glb_advance (
  input  logic                        glyph_present,
  input  logic [glb_pkg::GADV_W-1:0]  glyph_advance,
  input  logic [glb_pkg::SCALE_W-1:0] advance_scale,
  output logic [glb_pkg::WID_W-1:0]   adv
);

  localparam int unsigned PROD_W = glb_pkg::GADV_W + glb_pkg::SCALE_W;

  logic [PROD_W-1:0] prod;
  logic [PROD_W:0]   rounded;

  assign prod    = glyph_advance * advance_scale;
  assign rounded = {1'b0, prod} + (PROD_W+1)'(1 << (glb_pkg::FRAC_W - 1));

  // product >> 12 is at most 21 bits, always fits the width field
  assign adv = glyph_present
             ? glb_pkg::WID_W'(rounded[PROD_W:glb_pkg::FRAC_W])
             : '0;

endmodule

FILE: hdl/greedy_line_breaker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// greedy_line_breaker: greedy word-wrap line breaker
// Walks a stream of decoded code points, tracks byte offsets and line width,
// and emits one line record per newline, overflow or end of text.
// ----------------------------------------------------------------------------
//
//  channel | ports                                   | flow
//  --------+-----------------------------------------+---------------------
//  in      | in_valid/in_stall, cmd, code_point, ... | one code point/beat
//  out     | out_valid/out_stall, line_* fields      | zero or one per beat
//  cfg     | cfg_we, cfg_index, cfg_data             | write only, no wait
//
//  Throughput: one beat per cycle while out is not stalled with a record
//  waiting. A line record passes through the input register, then the state
//  update and output register, before it shows on out.
//  The rate is set by the line state update loop.
//  The advance multiply sits ahead of the input register, off that loop.
//  Reset (rst_n low, synchronous) clears the line state and sets the config
//  to no wrap, width 0, scale 1.0.
//  While out is stalled with a record waiting, beats that emit nothing keep
//  flowing; a beat that emits waits in the input register.
// ----------------------------------------------------------------------------
module greedy_line_breaker #(
  parameter int unsigned MAX_TEXT_BYTES = 65535
) (
  input  logic                          clk,
  input  logic                          rst_n,

  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          in_cmd,
  input  logic [glb_pkg::CP_W-1:0]      in_code_point,
  input  logic [glb_pkg::LEN_W-1:0]     in_byte_length,
  input  logic                          in_glyph_present,
  input  logic [glb_pkg::GADV_W-1:0]    in_glyph_advance,

  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [15:0]                   out_line_begin,
  output logic [15:0]                   out_line_finish,
  output logic [glb_pkg::WID_W-1:0]     out_line_width,
  output logic                          out_final_line,

  input  logic                          cfg_we,
  input  logic [glb_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [glb_pkg::CFG_DAT_W-1:0] cfg_data
);

  // Offset registers cover 0..MAX_TEXT_BYTES; output fields are the low 16.
  localparam int unsigned OFS_W = $clog2(MAX_TEXT_BYTES + 1);
  localparam int unsigned EXT_W = (OFS_W > 16) ? OFS_W : 16;
  localparam logic [OFS_W:0] OFS_MAX = (OFS_W+1)'(MAX_TEXT_BYTES);
  localparam int unsigned WID_W = glb_pkg::WID_W;

  // --------------------------------------------------------------------------
  // Config registers
  // --------------------------------------------------------------------------
  glb_pkg::glb_mode_t              wrap_mode_r;
  logic [WID_W-1:0]                wrap_width_r;
  logic [glb_pkg::SCALE_W-1:0]     adv_scale_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wrap_mode_r  <= glb_pkg::MODE_NONE;
      wrap_width_r <= '0;
      adv_scale_r  <= glb_pkg::SCALE_RESET;
    end else if (cfg_we) begin
      unique case (glb_pkg::glb_cfg_idx_t'(cfg_index))
        glb_pkg::CFG_WRAP_MODE: begin
          wrap_mode_r <= glb_pkg::glb_mode_t'(cfg_data[glb_pkg::MODE_W-1:0]);
        end
        glb_pkg::CFG_WRAP_WIDTH: begin
          wrap_width_r <= cfg_data[WID_W-1:0];
        end
        glb_pkg::CFG_ADV_SCALE: begin
          adv_scale_r <= cfg_data[glb_pkg::SCALE_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Input stage: classify the code point and scale the advance
  // --------------------------------------------------------------------------
  logic              in_take;
  logic [WID_W-1:0]  in_adv;
  glb_pkg::glb_item_t in_item;

  logic              s1_valid_r;
  glb_pkg::glb_item_t s1_r;
  logic              s2_go;

  glb_advance u_adv (
    .glyph_present (in_glyph_present),
    .glyph_advance (in_glyph_advance),
    .advance_scale (adv_scale_r),
    .adv           (in_adv)
  );

  assign in_item.eot      = (in_cmd == glb_pkg::CMD_EOT);
  assign in_item.newline  = (in_code_point == glb_pkg::CP_NEWLINE);
  assign in_item.brk_char = (in_code_point == glb_pkg::CP_SPACE) ||
                            (in_code_point == glb_pkg::CP_TAB);
  assign in_item.len      = in_byte_length;
  assign in_item.adv      = in_adv;

  assign in_stall = s1_valid_r && !s2_go;
  assign in_take  = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_take) begin
      s1_valid_r <= 1'b1;
    end else if (s2_go) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_r <= in_item;
    end
  end

  // --------------------------------------------------------------------------
  // Line state
  // --------------------------------------------------------------------------
  logic [OFS_W-1:0] bpos_r,  bpos_nxt;    // byte offset of next char
  logic [OFS_W-1:0] sol_r,   sol_nxt;     // start of current line
  logic [WID_W-1:0] run_r,   run_nxt;     // running width
  logic             brk_vld_r, brk_vld_nxt;
  logic [OFS_W-1:0] brk_pos_r, brk_pos_nxt;
  logic [WID_W-1:0] wbb_r,   wbb_nxt;     // width before break

  logic [OFS_W:0]   bpos_sum, brk_sum;
  logic [OFS_W-1:0] bpos_adv, brk_next;
  logic [WID_W:0]   run_sum, base_sum;
  logic [WID_W-1:0] run_base;
  logic             ovf, use_space;

  logic             emit;
  logic [OFS_W-1:0] rec_begin, rec_finish;
  logic [WID_W-1:0] rec_width;
  logic             rec_final;

  // offset after this char, saturated
  assign bpos_sum = {1'b0, bpos_r} + (OFS_W+1)'(s1_r.len);
  assign bpos_adv = (bpos_sum > OFS_MAX) ? OFS_MAX[OFS_W-1:0] : bpos_sum[OFS_W-1:0];

  // one past the remembered space, saturated
  assign brk_sum  = {1'b0, brk_pos_r} + (OFS_W+1)'(1);
  assign brk_next = (brk_sum > OFS_MAX) ? OFS_MAX[OFS_W-1:0] : brk_sum[OFS_W-1:0];

  // overflow test uses the unsaturated sum
  assign run_sum = {1'b0, run_r} + {1'b0, s1_r.adv};
  assign ovf = (wrap_mode_r != glb_pkg::MODE_NONE) && (wrap_width_r != '0) &&
               (run_sum > {1'b0, wrap_width_r}) && (run_r != '0);
  assign use_space = (wrap_mode_r == glb_pkg::MODE_SPACE) && brk_vld_r &&
                     (brk_pos_r > sol_r);

  always_comb begin
    bpos_nxt    = bpos_r;
    sol_nxt     = sol_r;
    run_base    = run_r;
    brk_vld_nxt = brk_vld_r;
    brk_pos_nxt = brk_pos_r;
    wbb_nxt     = wbb_r;
    emit        = 1'b0;
    rec_begin   = sol_r;
    rec_finish  = bpos_r;
    rec_width   = run_r;
    rec_final   = 1'b0;
    if (s1_r.eot) begin
      emit        = 1'b1;
      rec_final   = 1'b1;
      bpos_nxt    = '0;
      sol_nxt     = '0;
      run_base    = '0;
      brk_vld_nxt = 1'b0;
      brk_pos_nxt = '0;
      wbb_nxt     = '0;
    end else if (s1_r.newline) begin
      emit        = 1'b1;
      bpos_nxt    = bpos_adv;
      sol_nxt     = bpos_adv;
      run_base    = '0;
      brk_vld_nxt = 1'b0;
    end else begin
      bpos_nxt = bpos_adv;
      if (ovf) begin
        emit        = 1'b1;
        brk_vld_nxt = 1'b0;
        if (use_space) begin
          rec_finish = brk_pos_r;
          rec_width  = wbb_r;
          sol_nxt    = brk_next;
          run_base   = (run_r >= wbb_r) ? (run_r - wbb_r) : '0;
        end else begin
          sol_nxt  = bpos_r;
          run_base = '0;
        end
      end
      if ((wrap_mode_r == glb_pkg::MODE_SPACE) && s1_r.brk_char) begin
        brk_vld_nxt = 1'b1;
        brk_pos_nxt = bpos_r;
        wbb_nxt     = run_base;
      end
    end
  end

  // newline and end of text add nothing: base is zero and the advance is
  // only added on a plain char
  assign base_sum = {1'b0, run_base} +
                    ((s1_r.eot || s1_r.newline) ? '0 : {1'b0, s1_r.adv});
  assign run_nxt  = base_sum[WID_W] ? glb_pkg::WID_MAX : base_sum[WID_W-1:0];

  // --------------------------------------------------------------------------
  // Output register; a record only waits on a full, stalled slot
  // --------------------------------------------------------------------------
  logic              out_valid_r;
  logic              out_free;
  logic [EXT_W-1:0]  begin_ext, finish_ext;
  logic [15:0]       out_begin_r, out_finish_r;
  logic [WID_W-1:0]  out_width_r;
  logic              out_final_r;

  assign out_free = !out_valid_r || !out_stall;
  assign s2_go    = s1_valid_r && (!emit || out_free);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bpos_r    <= '0;
      sol_r     <= '0;
      run_r     <= '0;
      brk_vld_r <= 1'b0;
      brk_pos_r <= '0;
      wbb_r     <= '0;
    end else if (s2_go) begin
      bpos_r    <= bpos_nxt;
      sol_r     <= sol_nxt;
      run_r     <= run_nxt;
      brk_vld_r <= brk_vld_nxt;
      brk_pos_r <= brk_pos_nxt;
      wbb_r     <= wbb_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s2_go && emit) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  assign begin_ext  = EXT_W'(rec_begin);
  assign finish_ext = EXT_W'(rec_finish);

  always_ff @(posedge clk) begin
    if (s2_go && emit) begin
      out_begin_r  <= begin_ext[15:0];
      out_finish_r <= finish_ext[15:0];
      out_width_r  <= rec_width;
      out_final_r  <= rec_final;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_line_begin  = out_begin_r;
  assign out_line_finish = out_finish_r;
  assign out_line_width  = out_width_r;
  assign out_final_line  = out_final_r;

`ifndef SYNTHESIS
  // a held record is never overwritten by a new one
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && emit && out_valid_r && out_stall) |-> !s2_go)
    else $error("record issued into a full stalled output slot");

  // end of text returns the offsets to zero
  a_eot_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (s2_go && s1_r.eot) |=> (bpos_r == '0 && sol_r == '0 && run_r == '0))
    else $error("line state not cleared after end of text");

  // a newline drops the break point and restarts the width
  a_nl_restart: assert property (@(posedge clk) disable iff (!rst_n)
    (s2_go && !s1_r.eot && s1_r.newline) |=> (!brk_vld_r && run_r == '0))
    else $error("newline did not restart the line");

  // the input only stalls with a beat held that cannot move on
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (s1_valid_r && emit && out_valid_r && out_stall))
    else $error("input stalled without a blocked record");
`endif

endmodule

FILE: sim/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for greedy_line_breaker
// Drives code-point beats with random idle cycles and random result stalls.
// An in-bench line-layout predictor tracks offsets, widths and break points,
// and every line record that comes out is compared field by field against
// the oldest predicted record.
// ----------------------------------------------------------------------------
module testbench;

  localparam int unsigned WID_W     = glb_pkg::WID_W;
  localparam int unsigned CP_W      = glb_pkg::CP_W;
  localparam int unsigned LEN_W     = glb_pkg::LEN_W;
  localparam int unsigned GADV_W    = glb_pkg::GADV_W;
  localparam int unsigned SCALE_W   = glb_pkg::SCALE_W;
  localparam int unsigned FRAC_W    = glb_pkg::FRAC_W;
  localparam int unsigned MODE_W    = glb_pkg::MODE_W;
  localparam int unsigned CFG_IDX_W = glb_pkg::CFG_IDX_W;
  localparam int unsigned CFG_DAT_W = glb_pkg::CFG_DAT_W;

  localparam int unsigned TEXT_LIMIT  = 65535;  // byte offsets saturate here
  localparam int unsigned IDLE_PCT    = 38;     // idle/stall odds per cycle
  localparam int unsigned SETTLE_CYC  = 4;      // settle time for silent beats
  localparam int unsigned QUIET_LIMIT = 2000;   // cycles with no handshake or register write

  // One expected or observed line record.
  typedef struct packed {
    logic [15:0]      first_byte;
    logic [15:0]      end_byte;
    logic [WID_W-1:0] px;
    logic             last_line;
  } line_rec_t;

  logic clk;
  logic rst_n = 1'b0;

  // Every DUT input starts at a known value.
  logic                 in_valid         = 1'b0;
  logic                 in_cmd           = glb_pkg::CMD_CHAR;
  logic [CP_W-1:0]      in_code_point    = '0;
  logic [LEN_W-1:0]     in_byte_length   = '0;
  logic                 in_glyph_present = 1'b0;
  logic [GADV_W-1:0]    in_glyph_advance = '0;
  logic                 out_stall        = 1'b0;
  logic                 cfg_we           = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index        = '0;
  logic [CFG_DAT_W-1:0] cfg_data         = '0;

  logic              in_stall;
  logic              out_valid;
  logic [15:0]       out_line_begin;
  logic [15:0]       out_line_finish;
  logic [WID_W-1:0]  out_line_width;
  logic              out_final_line;

  greedy_line_breaker #(
    .MAX_TEXT_BYTES(TEXT_LIMIT)
  ) u_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_cmd           (in_cmd),
    .in_code_point    (in_code_point),
    .in_byte_length   (in_byte_length),
    .in_glyph_present (in_glyph_present),
    .in_glyph_advance (in_glyph_advance),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_line_begin   (out_line_begin),
    .out_line_finish  (out_line_finish),
    .out_line_width   (out_line_width),
    .out_final_line   (out_final_line),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // Line-layout predictor: its own copy of the registers and the line state.
  // --------------------------------------------------------------------------
  glb_pkg::glb_mode_t mode_cfg;
  logic [WID_W-1:0]   wrap_px;
  logic [15:0]        scale_cfg;

  logic [15:0]      byte_pos;    // offset of the next byte
  logic [15:0]      line_start;  // offset where the open line starts
  logic [WID_W-1:0] line_px;     // running width of the open line
  logic             brk_ok;      // a space/tab break point is held
  logic [15:0]      brk_at;      // offset of that space/tab
  logic [WID_W-1:0] px_at_brk;   // line width just before it

  line_rec_t pending_lines[$];
  int        mismatches = 0;

  function automatic logic [15:0] offset_add(logic [15:0] a, logic [16:0] b);
    logic [16:0] s;
    s = {1'b0, a} + b;
    return (s > TEXT_LIMIT) ? 16'(TEXT_LIMIT) : s[15:0];
  endfunction

  function automatic void clear_layout();
    byte_pos   = '0;
    line_start = '0;
    line_px    = '0;
    brk_ok     = 1'b0;
    brk_at     = '0;
    px_at_brk  = '0;
  endfunction

  // Advance the layout by one accepted beat; fire is set when a line closes.
  task automatic layout_step(input logic cmd, input logic [CP_W-1:0] cp,
                             input logic [LEN_W-1:0] len, input logic present,
                             input logic [GADV_W-1:0] raw,
                             output bit fire, output line_rec_t rec);
    logic [15:0]      char_at;
    logic [32:0]      prod;
    logic [WID_W-1:0] adv;
    logic [WID_W:0]   sum;
    fire = 1'b0;
    rec  = '0;
    if (cmd == glb_pkg::CMD_EOT) begin
      // end of text flushes the open line, registers survive
      rec  = {line_start, byte_pos, line_px, 1'b1};
      fire = 1'b1;
      clear_layout();
    end else begin
      char_at  = byte_pos;
      byte_pos = offset_add(byte_pos, 17'(len));  // odd lengths added as given
      if (cp == glb_pkg::CP_NEWLINE) begin
        rec        = {line_start, char_at, line_px, 1'b0};
        fire       = 1'b1;
        line_start = byte_pos;
        line_px    = '0;
        brk_ok     = 1'b0;
      end else begin
        // Q4.12 scale, round half up; a missing glyph takes no room
        prod = 33'(raw) * 33'(scale_cfg) + 33'd2048;
        adv  = present ? 24'(prod >> FRAC_W) : '0;
        // overflow test uses the unsaturated sum; an empty line never breaks
        sum  = {1'b0, line_px} + {1'b0, adv};
        if (mode_cfg != glb_pkg::MODE_NONE && wrap_px != '0 && sum > {1'b0, wrap_px} &&
            line_px != '0) begin
          fire = 1'b1;
          if (mode_cfg == glb_pkg::MODE_SPACE && brk_ok && brk_at > line_start) begin
            // break at the held space; the space's own advance carries over
            rec        = {line_start, brk_at, px_at_brk, 1'b0};
            line_start = offset_add(brk_at, 17'd1);
            line_px    = (line_px >= px_at_brk) ? line_px - px_at_brk : '0;
          end else begin
            // break before this character (also mode 3 and a leading space)
            rec        = {line_start, char_at, line_px, 1'b0};
            line_start = char_at;
            line_px    = '0;
          end
          brk_ok = 1'b0;
        end
        if (mode_cfg == glb_pkg::MODE_SPACE &&
            (cp == glb_pkg::CP_SPACE || cp == glb_pkg::CP_TAB)) begin
          brk_ok    = 1'b1;
          brk_at    = char_at;
          px_at_brk = line_px;
        end
        sum     = {1'b0, line_px} + {1'b0, adv};
        line_px = sum[WID_W] ? glb_pkg::WID_MAX : sum[WID_W-1:0];
      end
    end
  endtask

  // --------------------------------------------------------------------------
  // Scoreboard: checks the result beat first, then predicts the input beat,
  // all on values sampled at the same edge.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : scoreboard
    line_rec_t want;
    bit        fire;
    if (!rst_n) begin
      mode_cfg  = glb_pkg::MODE_NONE;
      wrap_px   = '0;
      scale_cfg = glb_pkg::SCALE_RESET;
      clear_layout();
      pending_lines.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (pending_lines.size() == 0) begin
          $display("%0t unexpected line record: expected none, got %0d..%0d px %0d final %0b",
                   $time, out_line_begin, out_line_finish, out_line_width,
                   out_final_line);
          mismatches++;
        end else begin
          want = pending_lines.pop_front();
          if (out_line_begin !== want.first_byte) begin
            $display("%0t line_begin: expected %0d, got %0d",
                     $time, want.first_byte, out_line_begin);
            mismatches++;
          end
          if (out_line_finish !== want.end_byte) begin
            $display("%0t line_finish: expected %0d, got %0d",
                     $time, want.end_byte, out_line_finish);
            mismatches++;
          end
          if (out_line_width !== want.px) begin
            $display("%0t line_width: expected %0d, got %0d",
                     $time, want.px, out_line_width);
            mismatches++;
          end
          if (out_final_line !== want.last_line) begin
            $display("%0t final_line: expected %0b, got %0b",
                     $time, want.last_line, out_final_line);
            mismatches++;
          end
        end
      end
      if (cfg_we) begin
        case (cfg_index)
          glb_pkg::CFG_WRAP_MODE:  mode_cfg  = glb_pkg::glb_mode_t'(cfg_data[MODE_W-1:0]);
          glb_pkg::CFG_WRAP_WIDTH: wrap_px   = cfg_data[WID_W-1:0];
          glb_pkg::CFG_ADV_SCALE:  scale_cfg = cfg_data[SCALE_W-1:0];
          default: ;  // unused index, no effect
        endcase
      end
      if (in_valid && !in_stall) begin
        layout_step(in_cmd, in_code_point, in_byte_length, in_glyph_present,
                    in_glyph_advance, fire, want);
        if (fire) pending_lines = {pending_lines, want};
      end
    end
  end

  // Watchdog: any handshake or register write counts as progress.
  int unsigned quiet_cycles = 0;
  always @(posedge clk) begin
    if (!rst_n || cfg_we || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------
  bit calm      = 1'b0;  // no idle cycles and no result stalls while set
  bit allow_eot = 1'b1;  // random text may end itself
  int adv_lo    = 100;   // glyph advance range for words
  int adv_hi    = 700;
  int fixed_len = 0;     // nonzero forces every letter to this byte length
  int beats_sent = 0;

  // Result side backpressure.
  always @(posedge clk) begin
    out_stall <= !calm && ($urandom_range(0, 99) < IDLE_PCT);
  end

  // Present one beat after a random gap; returns at the edge that takes it.
  task automatic send_beat(input logic cmd, input logic [CP_W-1:0] cp,
                           input logic [LEN_W-1:0] len, input logic present,
                           input logic [GADV_W-1:0] adv);
    while (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid         <= 1'b1;
    in_cmd           <= cmd;
    in_code_point    <= cp;
    in_byte_length   <= len;
    in_glyph_present <= present;
    in_glyph_advance <= adv;
    do @(posedge clk); while (in_stall);
    beats_sent++;
  endtask

  task automatic send_char(input logic [CP_W-1:0] cp, input logic [LEN_W-1:0] len,
                           input logic [GADV_W-1:0] adv);
    send_beat(glb_pkg::CMD_CHAR, cp, len, 1'b1, adv);
  endtask

  // End of text; the other fields are junk on purpose.
  task automatic send_eot();
    send_beat(glb_pkg::CMD_EOT, CP_W'($urandom), LEN_W'($urandom), 1'($urandom),
              GADV_W'($urandom));
  endtask

  // Stop feeding, let every expected line drain, then cover silent beats.
  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_lines.size() != 0) @(posedge clk);
    repeat (SETTLE_CYC) @(posedge clk);
  endtask

  // Register writes only on an idle block; the unused index gets poked too.
  task automatic set_config(input glb_pkg::glb_mode_t mode, input logic [WID_W-1:0] width,
                            input logic [SCALE_W-1:0] scale);
    wait_idle();
    cfg_we    <= 1'b1;
    cfg_index <= glb_pkg::CFG_WRAP_MODE;
    cfg_data  <= {22'($urandom), mode};
    @(posedge clk);
    cfg_index <= glb_pkg::CFG_WRAP_WIDTH;
    cfg_data  <= width;
    @(posedge clk);
    cfg_index <= glb_pkg::CFG_ADV_SCALE;
    cfg_data  <= {8'($urandom), scale};
    @(posedge clk);
    cfg_index <= glb_pkg::CFG_UNUSED;
    cfg_data  <= CFG_DAT_W'($urandom);
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // One word of mixed-script letters, lengths matching the code point unless fixed_len is set.
  task automatic send_word();
    int               n;
    int               kind;
    logic [CP_W-1:0]  cp;
    logic [LEN_W-1:0] len;
    n = $urandom_range(1, 8);
    repeat (n) begin
      kind = $urandom_range(0, 9);
      if (kind < 6) begin
        cp  = CP_W'(97 + $urandom_range(0, 25));
        len = 3'd1;
      end else if (kind < 8) begin
        cp  = CP_W'($urandom_range(32'h80, 32'h7FF));
        len = 3'd2;
      end else if (kind < 9) begin
        cp  = CP_W'($urandom_range(32'h800, 32'hFFFF));
        len = 3'd3;
      end else begin
        cp  = CP_W'($urandom_range(32'h10000, 32'h10FFFF));
        len = 3'd4;
      end
      if (fixed_len != 0) len = LEN_W'(fixed_len);
      send_beat(glb_pkg::CMD_CHAR, cp, len, $urandom_range(0, 19) != 0,
                GADV_W'($urandom_range(adv_lo, adv_hi)));
    end
  endtask

  task automatic send_separator();
    int               pick;
    logic [GADV_W-1:0] gap;
    pick = $urandom_range(0, 99);
    gap  = GADV_W'($urandom_range(adv_lo / 2, adv_hi / 2));
    if (pick < 55) begin
      send_char(glb_pkg::CP_SPACE, 3'd1, gap);
    end else if (pick < 72) begin
      send_char(glb_pkg::CP_TAB, 3'd1, gap);
    end else if (pick < 84) begin
      send_char(glb_pkg::CP_NEWLINE, 3'd1, gap);
    end else if (pick < 90) begin
      send_char(glb_pkg::CP_SPACE, 3'd1, gap);
      send_char(glb_pkg::CP_SPACE, 3'd1, gap);
    end else if (pick < 92 && allow_eot) begin
      send_eot();
    end
    // otherwise words run together
  endtask

  // Anything the ports allow: full-width code points, lengths 0..7, any advance.
  task automatic send_noise();
    logic cmd;
    cmd = (allow_eot && $urandom_range(0, 15) == 0) ? glb_pkg::CMD_EOT : glb_pkg::CMD_CHAR;
    send_beat(cmd, CP_W'($urandom), LEN_W'($urandom), 1'($urandom),
              GADV_W'($urandom));
  endtask

  // Mostly well-formed text with random content, some noise mixed in.
  task automatic run_text(input int n);
    int stop_at;
    stop_at = beats_sent + n;
    while (beats_sent < stop_at) begin
      if ($urandom_range(0, 9) < 8) begin
        send_word();
        send_separator();
      end else begin
        send_noise();
      end
    end
  endtask

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Reset config: no wrap, width 0, scale 1.0. Field extremes go through.
  task automatic test_reset_values();
    send_eot();                                                      // empty text
    send_char(CP_W'(65), 3'd1, 16'hFFFF);                            // widest advance
    send_beat(glb_pkg::CMD_CHAR, '0, 3'd0, 1'b0, 16'h1234);          // no glyph, zero length
    send_beat(glb_pkg::CMD_CHAR, {CP_W{1'b1}}, 3'd7, 1'b1, 16'h0000); // all-ones code point
    send_char(glb_pkg::CP_NEWLINE, 3'd1, 16'd500);
    send_char(CP_W'(32'h10FFFF), 3'd4, 16'd640);
    send_eot();
  endtask

  // Mode 1: break before the character that overflows, never on an empty line.
  task automatic test_char_wrap();
    set_config(glb_pkg::MODE_CHAR, 24'd1000, glb_pkg::SCALE_RESET);
    send_char(CP_W'(120), 3'd1, 16'd3000);  // wider than the line, line empty
    send_char(CP_W'(97), 3'd1, 16'd600);    // breaks
    send_char(CP_W'(98), 3'd1, 16'd400);    // exactly full, no break
    send_char(CP_W'(99), 3'd1, 16'd1);      // breaks
    send_eot();
  endtask

  // Mode 2: leading space is no break point, later tab is; newline clears it.
  task automatic test_space_wrap();
    set_config(glb_pkg::MODE_SPACE, 24'd1500, glb_pkg::SCALE_RESET);
    send_char(glb_pkg::CP_SPACE, 3'd1, 16'd300);
    send_char(CP_W'(97), 3'd1, 16'd400);
    send_char(CP_W'(98), 3'd1, 16'd400);
    send_char(CP_W'(99), 3'd1, 16'd500);    // falls back to a character break
    send_char(glb_pkg::CP_TAB, 3'd1, 16'd200);
    send_char(CP_W'(100), 3'd1, 16'd400);
    send_char(CP_W'(101), 3'd1, 16'd500);   // breaks at the tab
    send_char(glb_pkg::CP_NEWLINE, 3'd1, 16'd100);
    send_eot();
  endtask

  // Scale 0 kills every advance; full scale gives the largest one.
  task automatic test_scale_limits();
    set_config(glb_pkg::MODE_ALT, glb_pkg::WID_MAX, 16'd0);
    send_char(CP_W'(77), 3'd1, 16'hFFFF);
    set_config(glb_pkg::MODE_ALT, glb_pkg::WID_MAX, 16'hFFFF);
    send_char(CP_W'(77), 3'd1, 16'hFFFF);
    send_eot();
  endtask

  // Random text over a spread of register settings, extremes included.
  task automatic test_random_configs();
    glb_pkg::glb_mode_t mode;
    logic [WID_W-1:0]   width;
    logic [15:0]        scale;
    for (int ph = 0; ph < 10; ph++) begin
      adv_lo = 100;
      adv_hi = 700;
      scale  = glb_pkg::SCALE_RESET;
      case (ph)
        0: begin mode = glb_pkg::MODE_SPACE; width = WID_W'($urandom_range(1500, 6000)); end
        1: begin
          mode  = glb_pkg::MODE_CHAR;
          width = WID_W'($urandom_range(800, 4000));
          scale = 16'($urandom_range(2048, 8192));
        end
        2: begin mode = glb_pkg::MODE_ALT; width = WID_W'($urandom_range(800, 4000)); end
        3: begin mode = glb_pkg::MODE_NONE; width = WID_W'($urandom_range(800, 4000)); end
        4: begin mode = glb_pkg::MODE_SPACE; width = '0; end      // wrap disabled
        5: begin
          mode  = glb_pkg::MODE_SPACE;
          width = WID_W'(1);
          scale = 16'($urandom);
        end
        6: begin                                                 // near the top
          mode = glb_pkg::MODE_SPACE; width = glb_pkg::WID_MAX; scale = 16'hFFFF;
          adv_lo = 40000; adv_hi = 65535;
        end
        7: begin                                                 // width saturates
          mode = glb_pkg::MODE_NONE; width = glb_pkg::WID_MAX; scale = 16'hFFFF;
          adv_lo = 60000; adv_hi = 65535;
        end
        8: begin
          mode  = glb_pkg::MODE_SPACE;
          width = WID_W'($urandom_range(500, 3000));
          scale = '0;
        end
        default: begin
          mode   = glb_pkg::glb_mode_t'($urandom_range(0, 3));
          width  = WID_W'($urandom_range(0, 20000));
          scale  = 16'($urandom);
          adv_lo = 0;
          adv_hi = 2000;
        end
      endcase
      set_config(mode, width, scale);
      calm = (ph == 1);  // one long back-to-back stretch
      run_text(105);
      send_eot();
      calm = 1'b0;
    end
  endtask

  // One unbroken text with every letter at the largest length the port carries.
  task automatic test_long_text();
    set_config(glb_pkg::MODE_SPACE, 24'd5000, glb_pkg::SCALE_RESET);
    adv_lo    = 100;
    adv_hi    = 600;
    fixed_len = 7;
    allow_eot = 1'b0;
    run_text(250);
    fixed_len = 0;
    allow_eot = 1'b1;
    send_eot();
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_values();
    test_char_wrap();
    test_space_wrap();
    test_scale_limits();
    test_random_configs();
    test_long_text();

    wait_idle();
    repeat (SETTLE_CYC) @(posedge clk);
    if (mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

FILE: filelist.f
hdl/glb_pkg.sv
hdl/glb_advance.sv
hdl/greedy_line_breaker.sv
sim/testbench.sv
